// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;

  // Fixed port widths of the payload fields.
  localparam int KEY_W   = 16;
  localparam int TAG_W   = 16;
  localparam int COUNT_W = 5;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_DEQUEUE = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Port strobes from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// ===== hdl/spq_store.sv =====
module spq_store #(
  parameter int DEPTH = spq_pkg::DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH),
  parameter int EW    = spq_pkg::KEY_W + spq_pkg::TAG_W
) (
  input  logic              clk,
  input  spq_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [EW-1:0]     wr_data,
  output logic [EW-1:0]     rd_data
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
  parameter int SK       = spq_pkg::KEY_W,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1),
  parameter int EW       = SK + spq_pkg::TAG_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic                     command,
  input  logic [SK-1:0]            new_key,
  input  logic [spq_pkg::TAG_W-1:0] new_tag,
  output spq_pkg::mem_ctl_t        mem_ctl,
  output logic [AW-1:0]            rd_addr,
  output logic [AW-1:0]            wr_addr,
  output logic [EW-1:0]            wr_data,
  input  logic [EW-1:0]            rd_data,
  input  logic                     slot_free,
  output logic                     done,
  output spq_pkg::status_t         res_status,
  output logic                     res_out_valid,
  output logic [SK-1:0]            res_out_key,
  output logic [spq_pkg::TAG_W-1:0] res_out_tag,
  output logic                     res_head_valid,
  output logic [SK-1:0]            res_head_key,
  output logic [spq_pkg::TAG_W-1:0] res_head_tag,
  output logic [CW-1:0]            res_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_HEAD,
    S_DEQ_RD,
    S_DEQ_WR,
    S_DONE
  } state_t;

  state_t                    state;
  logic [CW-1:0]             count;
  logic [AW-1:0]             idx;
  logic [SK-1:0]             key_r;
  logic [spq_pkg::TAG_W-1:0] tag_r;
  logic [SK-1:0]             head_key;
  logic [spq_pkg::TAG_W-1:0] head_tag;
  logic [SK-1:0]             rd_key;
  logic                      shift_up;

  assign rd_key   = rd_data[EW-1 -: SK];
  // An older entry moves up while its key is not below the new key, so the
  // newest of equal keys ends up in front.
  assign shift_up = (rd_key >= key_r);

  assign item_ready     = (state == S_IDLE);
  assign done           = (state == S_DONE) && slot_free;
  assign res_count      = count;
  assign res_head_valid = (count != '0);
  assign res_head_key   = (count != '0) ? head_key : '0;
  assign res_head_tag   = (count != '0) ? head_tag : '0;

  // One memory access per state, and a read is always consumed in the state
  // after it, so a read never meets a pending write to the same entry.
  always_comb begin
    mem_ctl = '0;
    rd_addr = idx;
    wr_addr = '0;
    wr_data = {key_r, tag_r};
    case (state)
      S_IDLE: begin
        if (item_valid && (command == spq_pkg::CMD_INSERT) && (count == '0)) begin
          mem_ctl.wr_en = 1'b1;
          wr_data       = {new_key, new_tag};
        end
      end
      S_INS_RD: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_INS_CMP: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx + AW'(1);
        wr_data       = shift_up ? rd_data : {key_r, tag_r};
      end
      S_INS_HEAD: begin
        mem_ctl.wr_en = 1'b1;
      end
      S_DEQ_RD: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_DEQ_WR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx - AW'(1);
        wr_data       = rd_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            key_r         <= new_key;
            tag_r         <= new_tag;
            res_status    <= spq_pkg::STATUS_OK;
            res_out_valid <= 1'b0;
            res_out_key   <= '0;
            res_out_tag   <= '0;
            if (command == spq_pkg::CMD_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_status <= spq_pkg::STATUS_FULL;
                state      <= S_DONE;
              end else if (count == '0) begin
                head_key <= new_key;
                head_tag <= new_tag;
                count    <= CW'(1);
                state    <= S_DONE;
              end else begin
                idx   <= AW'(count - CW'(1));
                state <= S_INS_RD;
              end
            end else begin
              if (count == '0) begin
                res_status <= spq_pkg::STATUS_EMPTY;
                state      <= S_DONE;
              end else begin
                res_out_valid <= 1'b1;
                res_out_key   <= head_key;
                res_out_tag   <= head_tag;
                if (count == CW'(1)) begin
                  count <= '0;
                  state <= S_DONE;
                end else begin
                  idx   <= AW'(1);
                  state <= S_DEQ_RD;
                end
              end
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (shift_up) begin
            if (idx == '0) begin
              state <= S_INS_HEAD;
            end else begin
              idx   <= idx - AW'(1);
              state <= S_INS_RD;
            end
          end else begin
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_INS_HEAD: begin
          head_key <= key_r;
          head_tag <= tag_r;
          count    <= count + CW'(1);
          state    <= S_DONE;
        end
        S_DEQ_RD: begin
          state <= S_DEQ_WR;
        end
        S_DEQ_WR: begin
          if (idx == AW'(1)) begin
            head_key <= rd_key;
            head_tag <= rd_data[spq_pkg::TAG_W-1:0];
          end
          if (CW'(idx) == count - CW'(1)) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_DEQ_RD;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sorted_min_priority_queue.sv =====
// Channel   Handshake                    Payload
// item      item_valid / item_ready      command, new_key, new_tag
// result    result_valid / result_ready  status, out_valid, out_key, out_tag,
//                                        head_valid, head_key, head_tag, entry_count
//
// One item is in work at a time; the entries sit sorted in a single-port-read,
// single-port-write memory with a registered read; a copy of the front entry
// is kept in registers. An insert walks from the back toward the front, a read
// and a write per moved entry, until a compare stops the walk or the front is
// reached; a dequeue moves each remaining entry one place forward, a read and a
// write each. An insert into an empty queue, a dequeue of the last entry or any
// rejected item goes straight to the finish. Reset clears only the entry count,
// the sequencer state and the result valid flag. A result waiting in the output
// register does not block the next item; only the following finish stalls.
module sorted_min_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = spq_pkg::DEF_KEY_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        command,
  input  logic [spq_pkg::KEY_W-1:0]   new_key,
  input  logic [spq_pkg::TAG_W-1:0]   new_tag,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [1:0]                  status,
  output logic                        out_valid,
  output logic [spq_pkg::KEY_W-1:0]   out_key,
  output logic [spq_pkg::TAG_W-1:0]   out_tag,
  output logic                        head_valid,
  output logic [spq_pkg::KEY_W-1:0]   head_key,
  output logic [spq_pkg::TAG_W-1:0]   head_tag,
  output logic [spq_pkg::COUNT_W-1:0] entry_count
);

  localparam int SK = (KEY_BITS < spq_pkg::KEY_W) ? KEY_BITS : spq_pkg::KEY_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = SK + spq_pkg::TAG_W;

  spq_pkg::mem_ctl_t         mem_ctl;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [EW-1:0]             wr_data;
  logic [EW-1:0]             rd_data;
  logic                      slot_free;
  logic                      done;
  spq_pkg::status_t          res_status;
  logic                      res_out_valid;
  logic [SK-1:0]             res_out_key;
  logic [spq_pkg::TAG_W-1:0] res_out_tag;
  logic                      res_head_valid;
  logic [SK-1:0]             res_head_key;
  logic [spq_pkg::TAG_W-1:0] res_head_tag;
  logic [CW-1:0]             res_count;

  assign slot_free = !result_valid || result_ready;

  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .SK       (SK),
    .AW       (AW),
    .CW       (CW),
    .EW       (EW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .command        (command),
    .new_key        (new_key[SK-1:0]),
    .new_tag        (new_tag),
    .mem_ctl        (mem_ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_data        (rd_data),
    .slot_free      (slot_free),
    .done           (done),
    .res_status     (res_status),
    .res_out_valid  (res_out_valid),
    .res_out_key    (res_out_key),
    .res_out_tag    (res_out_tag),
    .res_head_valid (res_head_valid),
    .res_head_key   (res_head_key),
    .res_head_tag   (res_head_tag),
    .res_count      (res_count)
  );

  spq_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .EW    (EW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Output register: holds one finished result until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (done) begin
      status      <= res_status;
      out_valid   <= res_out_valid;
      out_key     <= spq_pkg::KEY_W'(res_out_key);
      out_tag     <= res_out_tag;
      head_valid  <= res_head_valid;
      head_key    <= spq_pkg::KEY_W'(res_head_key);
      head_tag    <= res_head_tag;
      entry_count <= spq_pkg::COUNT_W'(res_count);
    end
  end

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while another item is in work");

  a_dequeue_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_valid |-> status == spq_pkg::STATUS_OK)
    else $error("dequeued entry returned with an error status");

  a_empty_has_no_head: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == spq_pkg::STATUS_EMPTY) |-> !head_valid && !out_valid)
    else $error("dequeue on empty reports an entry");

  a_full_keeps_head: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == spq_pkg::STATUS_FULL) |-> head_valid && !out_valid)
    else $error("dropped insert reports a bad head or a dequeued entry");

endmodule

// ===== verif/tb_sorted_min_priority_queue.sv =====
module tb_sorted_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = spq_pkg::DEF_CAPACITY;
  localparam int KEY_BITS = spq_pkg::DEF_KEY_BITS;
  localparam int KEY_W = spq_pkg::KEY_W;
  localparam int TAG_W = spq_pkg::TAG_W;
  localparam int COUNT_W = spq_pkg::COUNT_W;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    spq_pkg::command_t  cmd;
    logic [KEY_W-1:0]   key;
    logic [TAG_W-1:0]   tag;
  } pq_item_t;

  typedef struct packed {
    spq_pkg::status_t   status;
    logic               out_valid;
    logic [KEY_W-1:0]   out_key;
    logic [TAG_W-1:0]   out_tag;
    logic               head_valid;
    logic [KEY_W-1:0]   head_key;
    logic [TAG_W-1:0]   head_tag;
    logic [COUNT_W-1:0] count;
  } pq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic command = 1'b0;
  logic [KEY_W-1:0] new_key = '0;
  logic [TAG_W-1:0] new_tag = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [1:0] status;
  logic out_valid;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic head_valid;
  logic [KEY_W-1:0] head_key;
  logic [TAG_W-1:0] head_tag;
  logic [COUNT_W-1:0] entry_count;

  sorted_min_priority_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .new_key      (new_key),
    .new_tag      (new_tag),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .out_valid    (out_valid),
    .out_key      (out_key),
    .out_tag      (out_tag),
    .head_valid   (head_valid),
    .head_key     (head_key),
    .head_tag     (head_tag),
    .entry_count  (entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pq_item_t   pending_items[$];
  pq_result_t expected_results[$];

  // Sorted copy of the queue contents, front entry at index zero.
  logic [KEY_W-1:0] held_key[CAPACITY];
  logic [TAG_W-1:0] held_tag[CAPACITY];
  int held_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  logic timed_out;

  assign timed_out = (idle_cycles >= WATCHDOG_LIMIT);

  function automatic pq_result_t queue_step(pq_item_t it);
    pq_result_t r;
    logic [KEY_W-1:0] k;
    int pos;
    int i;
    r = '0;
    r.status = spq_pkg::STATUS_OK;
    k = it.key & KEY_MASK;
    if (it.cmd == spq_pkg::CMD_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = spq_pkg::STATUS_FULL;
      end else begin
        // The new entry goes ahead of every entry with a key not below its own.
        pos = 0;
        while (pos < held_count && held_key[pos] < k) pos++;
        for (i = held_count; i > pos; i--) begin
          held_key[i] = held_key[i-1];
          held_tag[i] = held_tag[i-1];
        end
        held_key[pos] = k;
        held_tag[pos] = it.tag;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        r.out_valid = 1'b1;
        r.out_key = held_key[0];
        r.out_tag = held_tag[0];
        for (i = 0; i + 1 < held_count; i++) begin
          held_key[i] = held_key[i+1];
          held_tag[i] = held_tag[i+1];
        end
        held_count--;
      end
    end
    if (held_count > 0) begin
      r.head_valid = 1'b1;
      r.head_key = held_key[0];
      r.head_tag = held_tag[0];
    end
    r.count = COUNT_W'(held_count);
    return r;
  endfunction

  // Driver: a new item is offered only when the current one has been transferred.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(queue_step('{cmd: spq_pkg::command_t'(command),
                                                key: new_key, tag: new_tag}));
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          command <= pending_items[0].cmd;
          new_key <= pending_items[0].key;
          new_tag <= pending_items[0].tag;
          void'(pending_items.pop_front());
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  // The long receiver hold is counted down here, apart from the monitor.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left <= LONG_HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end
  end

  // Monitor: checks each result transfer and paces result_ready.
  always @(posedge clk) begin
    pq_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("out_valid", 32'(want.out_valid), 32'(out_valid));
          check_field("out_key", 32'(want.out_key), 32'(out_key));
          check_field("out_tag", 32'(want.out_tag), 32'(out_tag));
          check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
          check_field("head_key", 32'(want.head_key), 32'(head_key));
          check_field("head_tag", 32'(want.head_tag), 32'(head_tag));
          check_field("entry_count", 32'(want.count), 32'(entry_count));
        end
        results_seen++;
      end
      if (hold_left > 0 || (long_hold_req && !long_hold_done)) begin
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else if (idle_cycles < WATCHDOG_LIMIT)
      idle_cycles <= idle_cycles + 1;
  end

  task automatic add_item(spq_pkg::command_t c, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
    pending_items.push_back('{cmd: c, key: k, tag: t});
  endtask

  function automatic pq_item_t random_item(int insert_pct);
    pq_item_t it;
    it.cmd = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_DEQUEUE;
    // A narrow key range produces many ties.
    case ($urandom_range(5))
      0, 1: it.key = KEY_W'($urandom_range(7));
      2: it.key = '0;
      3: it.key = '1;
      default: it.key = KEY_W'($urandom);
    endcase
    it.tag = TAG_W'($urandom);
    return it;
  endfunction

  // Bursts that lean toward inserts or dequeues walk the fill level between
  // empty and full.
  task automatic add_random(int n);
    int i;
    int pct;
    pct = 50;
    for (i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0: pct = 80;
          1: pct = 25;
          default: pct = 55;
        endcase
      end
      pending_items.push_back(random_item(pct));
    end
  endtask

  task automatic wait_drained();
    while (!timed_out && (pending_items.size() != 0 || item_valid ||
                          expected_results.size() != 0))
      @(negedge clk);
  endtask

  task automatic run_phase(int n, int send_pct, int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    add_random(n);
    wait_drained();
  endtask

  initial begin
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    add_item(spq_pkg::CMD_DEQUEUE, '0, '0);
    add_item(spq_pkg::CMD_INSERT, '1, '1);
    add_item(spq_pkg::CMD_INSERT, '0, '0);
    // Equal keys: the later insert must come out first.
    add_item(spq_pkg::CMD_INSERT, 16'h0005, 16'h00AA);
    add_item(spq_pkg::CMD_INSERT, 16'h0005, 16'h00BB);
    add_item(spq_pkg::CMD_DEQUEUE, 16'hFFFF, 16'hFFFF);
    add_item(spq_pkg::CMD_DEQUEUE, 16'h1234, 16'h5678);
    for (i = 1; i <= 14; i++)
      add_item(spq_pkg::CMD_INSERT, KEY_W'(i * 16'h1111), TAG_W'(16'hFF00 + i));
    add_item(spq_pkg::CMD_INSERT, 16'h0001, 16'hC3C3);
    wait_drained();

    run_phase(150, 0, 0);
    run_phase(150, 55, 0);
    run_phase(150, 0, 55);
    run_phase(150, 15, 15);

    // The receiver holds off while the sender keeps offering items.
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    for (i = 0; i < 40; i++)
      pending_items.push_back(random_item(75));
    wait_drained();

    i = 0;
    while (!timed_out && i < DRAIN_CYCLES) begin
      @(negedge clk);
      i++;
    end

    if (timed_out || mismatches != 0 || expected_results.size() != 0)
      $display("[FAIL] regression broken");
    else
      $display("[ OK ] regression clean");
    $finish;
  end

endmodule
